// ===== src/fqd_pkg.sv =====
`default_nettype none

package fqd_pkg;

  localparam int unsigned FQD_DEPTH   = 16;
  localparam int unsigned FQD_VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_DEL = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } st_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic latch_in;
    logic rd_head;
    logic rd_ptr;
    logic wr_tail;
    logic wr_dst;
    logic head_adv;
    logic tail_adv;
    logic tail_set_ptr;
    logic cnt_inc;
    logic cnt_dec;
    logic ptr_load_head;
    logic ptr_adv;
    logic dst_load_ptr;
    logic rem_load_cnt;
    logic rem_dec;
    logic out_load;
    st_e  res_status;
    logic res_pop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    op_e  in_op;
    logic in_val_zero;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic rem_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/fifo_queue_with_delete.sv =====
// Channel | Dir | tuser (low bit up)  | tdata (low bit up)
// s_axis  | in  | operation[1:0]      | value[VALUE_WIDTH-1:0], zero pad to bytes
// m_axis  | out | status[2:0]         | out_value[VALUE_WIDTH-1:0], occupancy, zero pad
//
// Enqueue, dequeue, no-op and rejected operations go from accept straight to the result state.
// Delete walks the entry store one entry at a time (registered read, then compare or move),
// first to find the match and then to close up the entries behind it.
// Reset clears the head and tail pointers, the count and the output valid flag; entry store is left unset.
// A result waiting on m_axis does not stop the next item being accepted.

`default_nettype none

module fifo_queue_with_delete
  import fqd_pkg::*;
#(
  parameter int unsigned DEPTH       = FQD_DEPTH,
  parameter int unsigned VALUE_WIDTH = FQD_VALUE_W,
  localparam int unsigned CntW       = $clog2(DEPTH + 1),
  localparam int unsigned InW        = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutW       = ((VALUE_WIDTH + CntW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire logic [1:0]      s_axis_tuser_i,  // operation
  input  wire logic [InW-1:0]  s_axis_tdata_i,  // value
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  output logic [2:0]           m_axis_tuser_o,  // status
  output logic [OutW-1:0]      m_axis_tdata_o   // out_value, occupancy
);

  cmd_t                   cmd;
  stat_t                  stat;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [CntW-1:0]        out_occ;

  // Sequence each item: accept, walk the store for a delete, then load the result
  fqd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Entry store as a circular buffer, pointers, count and the output register
  fqd_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_valid_i   (s_axis_tvalid_i),
    .in_op_i      (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_occ_o    (out_occ)
  );

  assign s_axis_tready_o = cmd.in_ready;
  // Pack the result, padding with zeros up to whole bytes
  assign m_axis_tdata_o  = OutW'({out_occ, out_value});

  // Never count past full or below empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.cnt_full && cmd.cnt_inc))
    else $error("enqueue issued on a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.cnt_zero && cmd.cnt_dec))
    else $error("removal issued on an empty queue");

  // Reported length stays within the store
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_occ <= CntW'(DEPTH)))
    else $error("occupancy beyond depth");

  // Only a successful dequeue hands out a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && cmd.res_status != ST_OK |-> !cmd.res_pop)
    else $error("value returned with a failing status");

endmodule

`default_nettype wire

// ===== src/fqd_ctrl.sv =====
`default_nettype none

module fqd_ctrl
  import fqd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  st_e    status_q, status_d;
  logic   pop_q, pop_d;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    status_d = status_q;
    pop_d    = pop_q;

    cmd_o.in_ready   = (state_q == S_IDLE);
    cmd_o.res_status = status_q;
    cmd_o.res_pop    = pop_q;

    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          cmd_o.latch_in = 1'b1;
          pop_d          = 1'b0;
          status_d       = ST_OK;
          state_d        = S_RESP;
          unique case (stat_i.in_op)
            OP_ENQ: begin
              if (stat_i.in_val_zero) begin
                status_d = ST_NULL;
              end else if (stat_i.cnt_full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.wr_tail  = 1'b1;
                cmd_o.tail_adv = 1'b1;
                cmd_o.cnt_inc  = 1'b1;
              end
            end
            OP_DEQ: begin
              if (stat_i.cnt_zero) begin
                status_d = ST_EMPTY;
              end else begin
                cmd_o.rd_head  = 1'b1;
                cmd_o.head_adv = 1'b1;
                cmd_o.cnt_dec  = 1'b1;
                pop_d          = 1'b1;
              end
            end
            OP_DEL: begin
              if (stat_i.in_val_zero) begin
                status_d = ST_NULL;
              end else if (stat_i.cnt_zero) begin
                status_d = ST_NOTFOUND;
              end else begin
                cmd_o.ptr_load_head = 1'b1;
                cmd_o.rem_load_cnt  = 1'b1;
                state_d             = S_SCAN_RD;
              end
            end
            OP_NOP: begin
              status_d = ST_OK;
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          if (stat_i.rem_last) begin
            // match on the last entry: just drop it
            cmd_o.tail_set_ptr = 1'b1;
            cmd_o.cnt_dec      = 1'b1;
            state_d            = S_RESP;
          end else begin
            cmd_o.dst_load_ptr = 1'b1;
            cmd_o.ptr_adv      = 1'b1;
            cmd_o.rem_dec      = 1'b1;
            state_d            = S_SHIFT_RD;
          end
        end else if (stat_i.rem_last) begin
          status_d = ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          cmd_o.ptr_adv = 1'b1;
          cmd_o.rem_dec = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.wr_dst = 1'b1;
        if (stat_i.rem_last) begin
          cmd_o.tail_set_ptr = 1'b1;
          cmd_o.cnt_dec      = 1'b1;
          state_d            = S_RESP;
        end else begin
          cmd_o.dst_load_ptr = 1'b1;
          cmd_o.ptr_adv      = 1'b1;
          cmd_o.rem_dec      = 1'b1;
          state_d            = S_SHIFT_RD;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
      pop_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pop_q    <= pop_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/fqd_dpath.sv =====
`default_nettype none

module fqd_dpath
  import fqd_pkg::*;
#(
  parameter int unsigned DEPTH       = FQD_DEPTH,
  parameter int unsigned VALUE_WIDTH = FQD_VALUE_W,
  localparam int unsigned AddrW      = $clog2(DEPTH),
  localparam int unsigned CntW       = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output stat_t                       stat_o,
  input  wire logic                   in_valid_i,
  input  wire logic [1:0]             in_op_i,
  input  wire logic [VALUE_WIDTH-1:0] in_value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [2:0]                  out_status_o,
  output logic [VALUE_WIDTH-1:0]      out_value_o,
  output logic [CntW-1:0]             out_occ_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [AddrW-1:0]       head_q, tail_q, ptr_q, dst_q;
  logic [CntW-1:0]        count_q, rem_q;
  logic [VALUE_WIDTH-1:0] value_q, rdata_q;
  logic                   out_valid_q;
  st_e                    out_status_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic [CntW-1:0]        out_occ_q;

  logic [AddrW-1:0]       rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   rd_en, wr_en;

  function automatic logic [AddrW-1:0] nxt(input logic [AddrW-1:0] p);
    return (p == AddrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_en   = cmd_i.rd_head | cmd_i.rd_ptr;
  assign rd_addr = cmd_i.rd_head ? head_q : ptr_q;
  assign wr_en   = cmd_i.wr_tail | cmd_i.wr_dst;
  assign wr_addr = cmd_i.wr_tail ? tail_q : dst_q;
  assign wr_data = cmd_i.wr_tail ? in_value_i : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      value_q <= in_value_i;
    end
    if (cmd_i.ptr_load_head) begin
      ptr_q <= head_q;
    end else if (cmd_i.ptr_adv) begin
      ptr_q <= nxt(ptr_q);
    end
    if (cmd_i.dst_load_ptr) begin
      dst_q <= ptr_q;
    end
    if (cmd_i.rem_load_cnt) begin
      rem_q <= count_q;
    end else if (cmd_i.rem_dec) begin
      rem_q <= rem_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.res_status;
      out_value_q  <= cmd_i.res_pop ? rdata_q : '0;
      out_occ_q    <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.head_adv) begin
        head_q <= nxt(head_q);
      end
      if (cmd_i.tail_set_ptr) begin
        tail_q <= ptr_q;
      end else if (cmd_i.tail_adv) begin
        tail_q <= nxt(tail_q);
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.in_valid    = in_valid_i;
    stat_o.in_op       = op_e'(in_op_i);
    stat_o.in_val_zero = (in_value_i == '0);
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.cnt_full    = (count_q == CntW'(DEPTH));
    stat_o.match       = (rdata_q == value_q);
    stat_o.rem_last    = (rem_q == CntW'(1));
    stat_o.out_free    = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_occ_o    = out_occ_q;

endmodule

`default_nettype wire
